[src/uwp_pkg.sv]
`default_nettype none
package uwp_pkg;

  // saturation point of the byte count
  localparam int unsigned MAX_BYTES = 65536;
  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BYTES);

  // code point width and bounds
  localparam int CP_W = 21;
  localparam logic [CP_W-1:0] CP_MIN_2 = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN_3 = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4 = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;

  // queue between classifier and checker (power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // byte classes
  typedef enum logic [2:0] {
    CLS_ASCII = 3'd0,
    CLS_LEAD2 = 3'd1,
    CLS_LEAD3 = 3'd2,
    CLS_LEAD4 = 3'd3,
    CLS_CONT  = 3'd4,
    CLS_BAD   = 3'd5
  } byte_cls_t;

  // sequence lengths in continuation bytes
  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_TWO  = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR = 2'd3;

  // classified item
  typedef struct packed {
    logic      present;
    logic      last;
    byte_cls_t cls;
    logic [5:0] bits;
  } uwp_item_t;

  // front to queue
  typedef struct packed {
    logic      push;
    uwp_item_t item;
  } uwp_push_t;

  // queue to back
  typedef struct packed {
    logic      valid;
    uwp_item_t item;
  } uwp_head_t;

endpackage
`default_nettype wire

[src/uwp_if.sv]
`default_nettype none
// byte channel
interface uwp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last;

  modport source (output valid, output data_byte, output byte_present, output last,
                  input ready);
  modport sink (input valid, input data_byte, input byte_present, input last,
                output ready);
endinterface

// result channel
interface uwp_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] prefix_len;
  logic        well_formed;

  modport source (output valid, output prefix_len, output well_formed, input ready);
  modport sink (input valid, input prefix_len, input well_formed, output ready);
endinterface
`default_nettype wire

[src/utf8_wellformed_prefix.sv]
// the last item of a string is stored in the queue, then popped into the result register that drives out_ch
// throughput: one item per clock, sustained while out_ch takes results as they appear
// a two-entry queue parts the byte classifier from the sequence checker, and the result
//   register lets the next string run while a result waits to be taken
// reset: synchronous, active low rst_n; clears the queue, string state and result valid
`default_nettype none
module utf8_wellformed_prefix (
  input  wire logic clk,
  input  wire logic rst_n,
  uwp_in_if.sink    in_ch,
  uwp_out_if.source out_ch
);

  uwp_pkg::uwp_push_t push;
  uwp_pkg::uwp_head_t head;
  logic               q_full;
  logic               pop;

  // classify bytes
  uwp_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push_o (push)
  );

  // decouple classifier from checker
  uwp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .q_full (q_full),
    .head_o (head)
  );

  // track sequences and report
  uwp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head_i (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

[src/uwp_front.sv]
`default_nettype none
module uwp_front (
  uwp_in_if.sink                  in_ch,
  input  wire logic               q_full,
  output wire uwp_pkg::uwp_push_t push_o
);

  uwp_pkg::byte_cls_t cls;
  logic [5:0]         bits;

  // classify the byte and keep its payload bits
  always_comb begin
    cls  = uwp_pkg::CLS_BAD;
    bits = 6'd0;
    if (in_ch.data_byte inside {[8'h00:8'h7F]}) begin
      cls = uwp_pkg::CLS_ASCII;
    end else if (in_ch.data_byte inside {[8'h80:8'hBF]}) begin
      cls  = uwp_pkg::CLS_CONT;
      bits = in_ch.data_byte[5:0];
    end else if (in_ch.data_byte inside {[8'hC0:8'hDF]}) begin
      cls  = uwp_pkg::CLS_LEAD2;
      bits = {1'b0, in_ch.data_byte[4:0]};
    end else if (in_ch.data_byte inside {[8'hE0:8'hEF]}) begin
      cls  = uwp_pkg::CLS_LEAD3;
      bits = {2'b00, in_ch.data_byte[3:0]};
    end else if (in_ch.data_byte inside {[8'hF0:8'hF7]}) begin
      cls  = uwp_pkg::CLS_LEAD4;
      bits = {3'b000, in_ch.data_byte[2:0]};
    end
  end

  // accept whenever the queue has room
  assign in_ch.ready          = !q_full;
  assign push_o.push          = in_ch.valid && !q_full;
  assign push_o.item.present  = in_ch.byte_present;
  assign push_o.item.last     = in_ch.last;
  assign push_o.item.cls      = cls;
  assign push_o.item.bits     = bits;

endmodule
`default_nettype wire

[src/uwp_queue.sv]
`default_nettype none
module uwp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire uwp_pkg::uwp_push_t push_i,
  input  wire logic               pop,
  output logic                    q_full,
  output wire uwp_pkg::uwp_head_t head_o
);

  uwp_pkg::uwp_item_t mem [uwp_pkg::QDEPTH];
  logic [uwp_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [uwp_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [uwp_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign q_full       = (count_r == uwp_pkg::QCNT_W'(uwp_pkg::QDEPTH));
  assign head_o.valid = (count_r != '0);
  assign head_o.item  = mem[rd_ptr_r];
  assign do_push      = push_i.push && !q_full;
  assign do_pop       = pop && head_o.valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_i.item;
    end
  end

  // fill count stays within depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= uwp_pkg::QCNT_W'(uwp_pkg::QDEPTH))
    else $error("queue count above depth");

  // pointers stay apart by the fill count
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[uwp_pkg::QPTR_W-1:0])
    else $error("queue pointers out of step with count");

  // a push into a full queue does not change the count
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !do_pop |=> count_r == uwp_pkg::QCNT_W'(uwp_pkg::QDEPTH))
    else $error("queue overran");

endmodule
`default_nettype wire

[src/uwp_back.sv]
`default_nettype none
module uwp_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire uwp_pkg::uwp_head_t head_i,
  output logic                    pop,
  uwp_out_if.source               out_ch
);

  logic [uwp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [uwp_pkg::POS_W-1:0] start_r, start_nxt;
  logic [1:0]                rem_r, rem_nxt;
  logic [1:0]                seq_len_r, seq_len_nxt;
  logic [uwp_pkg::CP_W-1:0]  cp_r, cp_nxt;
  logic                      failed_r, failed_nxt;
  logic                      out_valid_r;
  logic [uwp_pkg::POS_W-1:0] out_len_r;
  logic                      out_ok_r;
  logic                      overlong, bad_value;
  uwp_pkg::uwp_item_t        it;

  assign it  = head_i.item;
  // only a last item has to wait for the result register
  assign pop = head_i.valid && (!it.last || !out_valid_r || out_ch.ready);

  // sequence tracking for one item
  always_comb begin
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    rem_nxt     = rem_r;
    seq_len_nxt = seq_len_r;
    cp_nxt      = cp_r;
    failed_nxt  = failed_r;
    overlong    = 1'b0;
    bad_value   = 1'b0;
    if (it.present) begin
      if (!failed_r) begin
        if (rem_r == 2'd0) begin
          start_nxt = pos_r;
          case (it.cls)
            uwp_pkg::CLS_ASCII: begin
            end
            uwp_pkg::CLS_LEAD2: begin
              seq_len_nxt = uwp_pkg::SEQ_TWO;
              rem_nxt     = uwp_pkg::SEQ_TWO;
              cp_nxt      = uwp_pkg::CP_W'(it.bits);
            end
            uwp_pkg::CLS_LEAD3: begin
              seq_len_nxt = uwp_pkg::SEQ_THREE;
              rem_nxt     = uwp_pkg::SEQ_THREE;
              cp_nxt      = uwp_pkg::CP_W'(it.bits);
            end
            uwp_pkg::CLS_LEAD4: begin
              seq_len_nxt = uwp_pkg::SEQ_FOUR;
              rem_nxt     = uwp_pkg::SEQ_FOUR;
              cp_nxt      = uwp_pkg::CP_W'(it.bits);
            end
            default: begin
              failed_nxt = 1'b1;
            end
          endcase
        end else if (it.cls != uwp_pkg::CLS_CONT) begin
          failed_nxt = 1'b1;
        end else begin
          cp_nxt  = {cp_r[uwp_pkg::CP_W-7:0], it.bits};
          rem_nxt = rem_r - 2'd1;
          if (rem_nxt == 2'd0) begin
            overlong = (seq_len_r == uwp_pkg::SEQ_TWO   && cp_nxt < uwp_pkg::CP_MIN_2) ||
                       (seq_len_r == uwp_pkg::SEQ_THREE && cp_nxt < uwp_pkg::CP_MIN_3) ||
                       (seq_len_r == uwp_pkg::SEQ_FOUR  && cp_nxt < uwp_pkg::CP_MIN_4);
            bad_value = (cp_nxt > uwp_pkg::CP_MAX) ||
                        (cp_nxt >= uwp_pkg::SURR_LO && cp_nxt <= uwp_pkg::SURR_HI);
            failed_nxt = overlong || bad_value;
          end
        end
      end
      // saturating byte count
      if (pos_r < uwp_pkg::POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  // string state, cleared after the last item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      start_r   <= '0;
      rem_r     <= '0;
      seq_len_r <= '0;
      cp_r      <= '0;
      failed_r  <= 1'b0;
    end else if (pop) begin
      if (it.last) begin
        pos_r     <= '0;
        start_r   <= '0;
        rem_r     <= '0;
        seq_len_r <= '0;
        cp_r      <= '0;
        failed_r  <= 1'b0;
      end else begin
        pos_r     <= pos_nxt;
        start_r   <= start_nxt;
        rem_r     <= rem_nxt;
        seq_len_r <= seq_len_nxt;
        cp_r      <= cp_nxt;
        failed_r  <= failed_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && it.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && it.last) begin
      if (failed_nxt || rem_nxt != 2'd0) begin
        out_len_r <= start_nxt;
        out_ok_r  <= 1'b0;
      end else begin
        out_len_r <= pos_nxt;
        out_ok_r  <= 1'b1;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.prefix_len  = out_len_r;
  assign out_ch.well_formed = out_ok_r;

  // open sequence never needs more than it announced
  a_rem_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= seq_len_r)
    else $error("remaining count above sequence length");

  // sequence start never runs ahead of the byte count
  a_start_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    start_r <= pos_r)
    else $error("sequence start beyond byte count");

  // state is clear after a last item
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pop && it.last |=> pos_r == '0 && rem_r == 2'd0 && !failed_r)
    else $error("string state not cleared");

  // a well-formed result carries the full count
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    pop && it.last && !failed_nxt && rem_nxt == 2'd0 |=> out_len_r == $past(pos_nxt))
    else $error("well-formed length mismatch");

endmodule
`default_nettype wire

[tb/sv/uwp_checker.sv]
module uwp_checker (
  input  logic clk,
  input  logic rst_n,
  uwp_in_if    in_mon,
  uwp_out_if   out_mon,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [uwp_pkg::POS_W-1:0] prefix_len;
    logic                      well_formed;
  } verdict_t;

  // verdicts of finished strings, oldest first
  verdict_t prefix_verdicts[$];
  int       fail_count = 0;
  int       pending_cnt = 0;

  assign errors      = fail_count;
  assign outstanding = pending_cnt;

  // state of the string being validated
  logic [uwp_pkg::POS_W-1:0] bytes_taken;
  logic [uwp_pkg::POS_W-1:0] seq_origin;
  logic [1:0]                cont_left;
  logic [1:0]                cont_need;
  logic [uwp_pkg::CP_W-1:0]  cp_acc;
  logic                      broken;

  function automatic void start_string();
    bytes_taken = '0;
    seq_origin  = '0;
    cont_left   = uwp_pkg::SEQ_NONE;
    cont_need   = uwp_pkg::SEQ_NONE;
    cp_acc      = '0;
    broken      = 1'b0;
  endfunction

  function automatic uwp_pkg::byte_cls_t class_of(input logic [7:0] b);
    if (b[7] == 1'b0) return uwp_pkg::CLS_ASCII;
    if (b[7:6] == 2'b10) return uwp_pkg::CLS_CONT;
    if (b[7:5] == 3'b110) return uwp_pkg::CLS_LEAD2;
    if (b[7:4] == 4'b1110) return uwp_pkg::CLS_LEAD3;
    if (b[7:3] == 5'b11110) return uwp_pkg::CLS_LEAD4;
    return uwp_pkg::CLS_BAD;
  endfunction

  // one byte into the open sequence; the count saturates
  function automatic void absorb_byte(input logic [7:0] b);
    uwp_pkg::byte_cls_t cls;
    logic               overlong;
    logic               bad_value;
    cls = class_of(b);
    if (!broken) begin
      if (cont_left == uwp_pkg::SEQ_NONE) begin
        seq_origin = bytes_taken;
        case (cls)
          uwp_pkg::CLS_ASCII: ;
          uwp_pkg::CLS_LEAD2: begin
            cont_need = uwp_pkg::SEQ_TWO;
            cp_acc    = uwp_pkg::CP_W'(b[4:0]);
          end
          uwp_pkg::CLS_LEAD3: begin
            cont_need = uwp_pkg::SEQ_THREE;
            cp_acc    = uwp_pkg::CP_W'(b[3:0]);
          end
          uwp_pkg::CLS_LEAD4: begin
            cont_need = uwp_pkg::SEQ_FOUR;
            cp_acc    = uwp_pkg::CP_W'(b[2:0]);
          end
          default: broken = 1'b1;
        endcase
        if (!broken && cls != uwp_pkg::CLS_ASCII) cont_left = cont_need;
      end else if (cls != uwp_pkg::CLS_CONT) begin
        broken = 1'b1;
      end else begin
        cp_acc    = {cp_acc[uwp_pkg::CP_W-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == uwp_pkg::SEQ_NONE) begin
          overlong  = (cont_need == uwp_pkg::SEQ_TWO   && cp_acc < uwp_pkg::CP_MIN_2) ||
                      (cont_need == uwp_pkg::SEQ_THREE && cp_acc < uwp_pkg::CP_MIN_3) ||
                      (cont_need == uwp_pkg::SEQ_FOUR  && cp_acc < uwp_pkg::CP_MIN_4);
          bad_value = cp_acc > uwp_pkg::CP_MAX ||
                      (cp_acc >= uwp_pkg::SURR_LO && cp_acc <= uwp_pkg::SURR_HI);
          if (overlong || bad_value) broken = 1'b1;
        end
      end
    end
    if (bytes_taken < uwp_pkg::POS_MAX) bytes_taken = bytes_taken + 1'b1;
  endfunction

  // verdict at the end of a string, then a fresh string
  function automatic verdict_t close_string();
    verdict_t v;
    if (broken || cont_left != uwp_pkg::SEQ_NONE) begin
      v.prefix_len  = seq_origin;
      v.well_formed = 1'b0;
    end else begin
      v.prefix_len  = bytes_taken;
      v.well_formed = 1'b1;
    end
    start_string();
    return v;
  endfunction

  // results are checked before the item of the same edge is absorbed
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      start_string();
      prefix_verdicts.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (prefix_verdicts.size() == 0) begin
          $display("%0t: unexpected result, expected none, got prefix_len %0d well_formed %0b",
                   $time, out_mon.prefix_len, out_mon.well_formed);
          fail_count++;
        end else begin
          want = prefix_verdicts.pop_front();
          if (out_mon.prefix_len !== want.prefix_len) begin
            $display("%0t: prefix_len expected %0d, got %0d",
                     $time, want.prefix_len, out_mon.prefix_len);
            fail_count++;
          end
          if (out_mon.well_formed !== want.well_formed) begin
            $display("%0t: well_formed expected %0b, got %0b",
                     $time, want.well_formed, out_mon.well_formed);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.byte_present) absorb_byte(in_mon.data_byte);
        if (in_mon.last) prefix_verdicts.push_back(close_string());
      end
    end
    pending_cnt <= prefix_verdicts.size();
  end

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  localparam int RANDOM_ITEMS = 1400;
  localparam int CALM_TAIL    = 250;
  localparam int QUIET_LIMIT  = 1000;

  logic clk;
  logic rst_n;
  int   errors;
  int   outstanding;
  int   quiet_cycles = 0;
  int   stall_left = 0;
  bit   bursts_on = 1'b1;
  bit   calm = 1'b0;
  bit   noisy = 1'b0;

  uwp_in_if  in_ch ();
  uwp_out_if out_ch ();

  utf8_wellformed_prefix dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  uwp_checker prefix_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // result side back-pressure in bursts of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (bursts_on && !calm && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 5);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic byte_q_t encode(input logic [uwp_pkg::CP_W-1:0] cp, input int n);
    byte_q_t c;
    case (n)
      1: c.push_back({1'b0, cp[6:0]});
      2: begin
        c.push_back({3'b110, cp[10:6]});
        c.push_back({2'b10, cp[5:0]});
      end
      3: begin
        c.push_back({4'b1110, cp[15:12]});
        c.push_back({2'b10, cp[11:6]});
        c.push_back({2'b10, cp[5:0]});
      end
      default: begin
        c.push_back({5'b11110, cp[20:18]});
        c.push_back({2'b10, cp[17:12]});
        c.push_back({2'b10, cp[11:6]});
        c.push_back({2'b10, cp[5:0]});
      end
    endcase
    return c;
  endfunction

  // a legal code point for an n-byte form, often at the edges of its range
  function automatic logic [uwp_pkg::CP_W-1:0] valid_cp(input int n);
    logic [uwp_pkg::CP_W-1:0] lo;
    logic [uwp_pkg::CP_W-1:0] hi;
    logic [uwp_pkg::CP_W-1:0] cp;
    case (n)
      1: begin
        lo = '0;
        hi = uwp_pkg::CP_W'(uwp_pkg::CP_MIN_2 - 1);
      end
      2: begin
        lo = uwp_pkg::CP_MIN_2;
        hi = uwp_pkg::CP_W'(uwp_pkg::CP_MIN_3 - 1);
      end
      3: begin
        lo = uwp_pkg::CP_MIN_3;
        hi = uwp_pkg::CP_W'(uwp_pkg::CP_MIN_4 - 1);
      end
      default: begin
        lo = uwp_pkg::CP_MIN_4;
        hi = uwp_pkg::CP_MAX;
      end
    endcase
    case ($urandom_range(0, 9))
      0: cp = lo;
      1: cp = hi;
      2: cp = (n == 3) ? uwp_pkg::CP_W'(uwp_pkg::SURR_LO - 1) : lo;
      3: cp = (n == 3) ? uwp_pkg::CP_W'(uwp_pkg::SURR_HI + 1) : hi;
      default: cp = uwp_pkg::CP_W'($urandom_range(lo, hi));
    endcase
    // step over the surrogate block
    if (n == 3 && cp >= uwp_pkg::SURR_LO && cp <= uwp_pkg::SURR_HI) begin
      cp = uwp_pkg::CP_W'(cp + (uwp_pkg::SURR_HI - uwp_pkg::SURR_LO + 1));
    end
    return cp;
  endfunction

  function automatic byte_q_t good_char();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = 1;
      4, 5:       n = 2;
      6, 7:       n = 3;
      default:    n = 4;
    endcase
    return encode(valid_cp(n), n);
  endfunction

  // one piece, mostly ill-formed: overlong, surrogate, too large, a broken continuation, stray or random bytes
  function automatic byte_q_t bad_char();
    byte_q_t                  c;
    logic [uwp_pkg::CP_W-1:0] cp;
    logic [7:0]               b;
    int                       n;
    n = $urandom_range(2, 4);
    case ($urandom_range(0, 6))
      0: begin
        cp = (n == 2) ? uwp_pkg::CP_W'(uwp_pkg::CP_MIN_2 - 1) :
             (n == 3) ? uwp_pkg::CP_W'(uwp_pkg::CP_MIN_3 - 1) :
                        uwp_pkg::CP_W'(uwp_pkg::CP_MIN_4 - 1);
        if ($urandom_range(0, 1) == 1) cp = uwp_pkg::CP_W'($urandom_range(0, cp));
        c = encode(cp, n);
      end
      1: c = encode(uwp_pkg::CP_W'($urandom_range(uwp_pkg::SURR_LO, uwp_pkg::SURR_HI)), 3);
      2: begin
        cp = uwp_pkg::CP_W'(uwp_pkg::CP_MAX + 1);
        if ($urandom_range(0, 2) != 0) begin
          cp = uwp_pkg::CP_W'($urandom_range(uwp_pkg::CP_MAX + 1, {uwp_pkg::CP_W{1'b1}}));
        end
        c = encode(cp, 4);
      end
      3: c.push_back(8'($urandom_range(8'h80, 8'hBF)));
      4: c.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      5: begin
        // a continuation replaced by a byte that is not one
        c = encode(valid_cp(n), n);
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        c[$urandom_range(1, n - 1)] = b;
      end
      default: c.push_back(8'($urandom_range(0, 255)));
    endcase
    return c;
  endfunction

  function automatic void append_bytes(ref byte_q_t dst, input byte_q_t src);
    foreach (src[i]) dst.push_back(src[i]);
  endfunction

  // one item over the byte channel, with an optional idle burst ahead of it
  task automatic send_item(input logic [7:0] b, input logic present, input logic fin);
    if (bursts_on && !calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.byte_present <= present;
    in_ch.last         <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // a string, ended on its final byte or by an item with no byte
  task automatic send_string(input byte_q_t s, input bit term);
    int n;
    n = s.size();
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(s[i], 1'b1, !term && i == n - 1);
    end
    if (term || n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    byte_q_t s;
    byte_q_t c;
    int      random_items;
    int      r;
    int      n;
    int      m;
    int      k;
    bit      term;
    random_items       = 0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.byte_present = 1'b0;
    in_ch.last         = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty string, then an ignored item ahead of two ascii bytes
    s.delete();
    send_string(s, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    s = {8'h00, 8'h7F};
    send_string(s, 1'b0);
    // two-byte forms at both ends of their range
    s = {8'hC2, 8'h80, 8'hDF, 8'hBF};
    send_string(s, 1'b0);
    // surrogate
    s = {8'hED, 8'hA0, 8'h80};
    send_string(s, 1'b0);
    // beyond the last code point
    s = {8'hF4, 8'h90, 8'h80, 8'h80};
    send_string(s, 1'b0);
    // lone continuation after a good byte
    s = {8'h41, 8'h80};
    send_string(s, 1'b0);
    // bad lead byte
    s = {8'hFF};
    send_string(s, 1'b0);
    // overlong two-byte form
    s = {8'hC1, 8'hBF};
    send_string(s, 1'b0);
    // missing continuation
    s = {8'hE2, 8'h41};
    send_string(s, 1'b0);
    // sequence cut off, string ended by an item with no byte
    s = {8'h41, 8'hF0, 8'h90};
    send_string(s, 1'b1);
    drain_results();

    // random strings: mostly well formed, some broken, cut off or raw bytes
    noisy = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= RANDOM_ITEMS - CALM_TAIL) bursts_on = 1'b0;
      calm = ($urandom_range(0, 4) == 0);
      s.delete();
      r = $urandom_range(0, 19);
      n = $urandom_range(0, 8);
      if (r < 18) begin
        k = -1;
        if (r >= 12 && r < 17) k = $urandom_range(0, n);
        for (int i = 0; i <= n; i++) begin
          if (i == k) append_bytes(s, bad_char());
          if (i < n) append_bytes(s, good_char());
        end
        if (r == 17) begin
          m = $urandom_range(2, 4);
          c = encode(valid_cp(m), m);
          repeat ($urandom_range(1, m - 1)) void'(c.pop_back());
          append_bytes(s, c);
        end
      end else begin
        repeat (n + 1) s.push_back(8'($urandom_range(0, 255)));
      end
      term = (s.size() == 0) || ($urandom_range(0, 4) == 0);
      send_string(s, term);
      random_items += s.size() + (term ? 1 : 0);
      if ($urandom_range(0, 39) == 0) drain_results();
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
